// File: hdl/hbtm_pkg.sv
// Shared constants and codes for the heartbeat timeout monitor.
package hbtm_pkg;

  // Default channel count and the number of channels the tables describe.
  localparam int CHANNELS_DEF = 8;
  localparam int TABLE_SLOTS  = 8;

  // Field widths.
  localparam int ELAPSED_W  = 9;
  localparam int OP_W       = 2;
  localparam int CHAN_W     = 3;
  localparam int TIMEOUT_W  = 8;
  localparam int PRIO_W     = 4;
  localparam int COUNT_W    = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Register reset values.
  localparam logic [TABLE_SLOTS-1:0]           ENABLE_RESET   = '0;
  localparam logic [TABLE_SLOTS*TIMEOUT_W-1:0] TIMEOUT_RESET  = 64'hC8C8_C8C8_C8C8_C8C8;
  localparam logic [TABLE_SLOTS*PRIO_W-1:0]    PRIORITY_RESET = '0;

  // Item operation codes.
  localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
  localparam logic [OP_W-1:0] OP_HEARTBEAT = 2'd1;
  localparam logic [OP_W-1:0] OP_SCAN      = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PRIORITY = 2'd2;

endpackage

// File: hdl/heartbeat_timeout_monitor_top.sv
// Heartbeat timeout monitor: per-channel elapsed counters, a sequenced tick walk and scan.
//
//   Channel  Direction  Handshake           Payload
//   in_      slave      in_tvalid/tready    tuser: op; tdata: channel
//   out_     master     out_tvalid/tready   tdata: flags, count, top_valid, top_channel
//   cfg_     write      cfg_we              cfg_addr selects register, cfg_wdata value
//
// A tick word walks the elapsed counters: one shared saturating incrementer visits one
// elapsed counter per cycle. A heartbeat word is handled in the idle state. A scan word
// walks min(CHANNELS, 8) channels: one shared compare and priority stage visits one
// channel per cycle, then the result is loaded into the output register once it is free.
// The input is ready only in the idle state. rst_n is synchronous and active low; it
// clears the counters and the output valid and resets the configuration registers. A
// stalled output holds its word; ticks and heartbeats go on and a new scan result waits.
module heartbeat_timeout_monitor_top #(
  parameter int CHANNELS = hbtm_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input words.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hbtm_pkg::IN_DATA_W-1:0]    in_tdata,   // [2:0] channel, rest zero
  input  logic [hbtm_pkg::OP_W-1:0]         in_tuser,   // [1:0] op
  // Scan results.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] error_flags, [11:8] error_count, [12] top_valid, [15:13] top_channel
  output logic [hbtm_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Configuration writes.
  input  logic                              cfg_we,
  input  logic [hbtm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [hbtm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SLOTS  = hbtm_pkg::TABLE_SLOTS;
  localparam int SCAN_N = (CHANNELS < SLOTS) ? CHANNELS : SLOTS;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(CHANNELS + 1);
  localparam int EW     = hbtm_pkg::ELAPSED_W;
  localparam int TW     = hbtm_pkg::TIMEOUT_W;
  localparam int PW     = hbtm_pkg::PRIO_W;
  localparam int NW     = hbtm_pkg::COUNT_W;
  localparam int SW     = hbtm_pkg::CHAN_W;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TICK = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [EW-1:0]         elapsed_r [CHANNELS];

  logic [SLOTS-1:0]      enable_r;
  logic [SLOTS*TW-1:0]   timeout_r;
  logic [SLOTS*PW-1:0]   priority_r;

  // Scan accumulators.
  logic [SLOTS-1:0]      flags_r, flags_nxt;
  logic [NW-1:0]         count_r, count_nxt;
  logic [PW-1:0]         best_r, best_nxt;
  logic [SW-1:0]         top_r, top_nxt;
  logic                  valid_r, valid_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [hbtm_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                  in_fire;
  logic [SW-1:0]         in_chan;
  logic [CH_W-1:0]       hb_idx;
  logic                  hb_ok;
  logic [CH_W-1:0]       idx;
  logic [3:0]            cnt_ext;
  logic [SW-1:0]         slot;
  logic [EW-1:0]         cur_elapsed;
  logic [TW-1:0]         cur_timeout;
  logic [PW-1:0]         cur_prio;
  logic                  hit;
  logic                  tick_last;
  logic                  scan_last;
  logic                  elapsed_we;
  logic [CH_W-1:0]       elapsed_waddr;
  logic [EW-1:0]         elapsed_wdata;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_chan    = in_tdata[SW-1:0];
  assign hb_idx     = CH_W'(in_chan);
  // A heartbeat counts only for an existing, enabled channel.
  assign hb_ok      = (32'(in_chan) < CHANNELS) && enable_r[in_chan];

  // The walk counter picks the elapsed entry and, during a scan, the table slot.
  assign idx         = cnt_r[CH_W-1:0];
  assign cnt_ext     = 4'(cnt_r);
  assign slot        = cnt_ext[SW-1:0];
  assign cur_elapsed = elapsed_r[idx];
  assign cur_timeout = timeout_r[TW*slot +: TW];
  assign cur_prio    = priority_r[PW*slot +: PW];
  assign hit         = enable_r[slot] && (cur_elapsed > EW'(cur_timeout));
  assign tick_last   = (cnt_r == CNT_W'(CHANNELS - 1));
  assign scan_last   = (cnt_r == CNT_W'(SCAN_N - 1));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    flags_nxt     = flags_r;
    count_nxt     = count_r;
    best_nxt      = best_r;
    top_nxt       = top_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    elapsed_we    = 1'b0;
    elapsed_waddr = idx;
    elapsed_wdata = cur_elapsed;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_nxt = '0;
          if (in_tuser == hbtm_pkg::OP_TICK) begin
            state_nxt = ST_TICK;
          end else if (in_tuser == hbtm_pkg::OP_HEARTBEAT) begin
            elapsed_we    = hb_ok;
            elapsed_waddr = hb_idx;
            elapsed_wdata = '0;
          end else if (in_tuser == hbtm_pkg::OP_SCAN) begin
            flags_nxt = '0;
            count_nxt = '0;
            best_nxt  = '0;
            top_nxt   = '0;
            valid_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_TICK: begin
        // Saturating increment of one counter per cycle.
        elapsed_we = (cur_elapsed != hbtm_pkg::ELAPSED_MAX);
        elapsed_wdata = cur_elapsed + EW'(1);
        cnt_nxt = cnt_r + CNT_W'(1);
        if (tick_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          flags_nxt[slot] = 1'b1;
          count_nxt = count_r + NW'(1);
          // Strictly greater keeps the lowest index on a tie; zero never selects.
          if (cur_prio > best_r) begin
            best_nxt  = cur_prio;
            top_nxt   = slot;
            valid_nxt = 1'b1;
          end
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {top_r, valid_r, count_r, flags_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      enable_r    <= hbtm_pkg::ENABLE_RESET;
      timeout_r   <= hbtm_pkg::TIMEOUT_RESET;
      priority_r  <= hbtm_pkg::PRIORITY_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        elapsed_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (elapsed_we) begin
        elapsed_r[elapsed_waddr] <= elapsed_wdata;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          hbtm_pkg::REG_ENABLE:   enable_r   <= cfg_wdata[SLOTS-1:0];
          hbtm_pkg::REG_TIMEOUT:  timeout_r  <= cfg_wdata[SLOTS*TW-1:0];
          hbtm_pkg::REG_PRIORITY: priority_r <= cfg_wdata[SLOTS*PW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    flags_r    <= flags_nxt;
    count_r    <= count_nxt;
    best_r     <= best_nxt;
    top_r      <= top_nxt;
    valid_r    <= valid_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
